FILE: rtl/smrcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smrcg_pkg
// Shared types, register codes and clipping helpers for the sprite move
// rectangle command generator.
// ----------------------------------------------------------------------------
package smrcg_pkg;

    localparam int DISPLAY_WIDTH  = 240;
    localparam int DISPLAY_HEIGHT = 320;

    localparam int CW        = 14;
    localparam int NUM_CMD   = 10;
    localparam int NUM_ERASE = 2;
    localparam int POS_MAX   = 511;

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord DISP_W  = t_coord'(DISPLAY_WIDTH);
    localparam t_coord DISP_H  = t_coord'(DISPLAY_HEIGHT);
    localparam t_coord POS_TOP = t_coord'(POS_MAX);

    localparam logic OP_MOVE  = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    typedef enum logic [2:0] {
        CFG_BORDER_LEFT   = 3'd0,
        CFG_BORDER_TOP    = 3'd1,
        CFG_BORDER_WIDTH  = 3'd2,
        CFG_BORDER_HEIGHT = 3'd3,
        CFG_SPRITE_WIDTH  = 3'd4,
        CFG_SPRITE_HEIGHT = 3'd5,
        CFG_FG_COLOR      = 3'd6,
        CFG_BG_COLOR      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic       vld;
        logic [7:0] x;
        logic [8:0] y;
        logic [7:0] w;
        logic [8:0] h;
    } t_cmd;

    function automatic t_cmd make_cmd(input logic ok, input t_coord x, input t_coord y,
                                      input t_coord w, input t_coord h);
        t_cmd c;
        c.vld = ok;
        c.x   = x[7:0];
        c.y   = y[8:0];
        c.w   = w[7:0];
        c.h   = h[8:0];
        return c;
    endfunction

    function automatic t_coord clampv(input t_coord v, input t_coord lo, input t_coord hi);
        t_coord r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [8:0] sat9(input t_coord v);
        logic [8:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > POS_TOP) begin
            r = '1;
        end else begin
            r = v[8:0];
        end
        return r;
    endfunction

    function automatic t_cmd fill_clipped(input t_coord x_in, input t_coord y_in,
                                          input t_coord w_in, input t_coord h_in);
        t_coord x;
        t_coord y;
        t_coord w;
        t_coord h;
        logic   ok;
        x  = x_in;
        y  = y_in;
        w  = w_in;
        h  = h_in;
        ok = (w > 0) && (h > 0);
        if (x < 0) begin
            w = w + x;
            x = '0;
        end
        if (y < 0) begin
            h = h + y;
            y = '0;
        end
        if (x >= DISP_W || y >= DISP_H) begin
            ok = 1'b0;
        end
        if (x + w > DISP_W) begin
            w = DISP_W - x;
        end
        if (y + h > DISP_H) begin
            h = DISP_H - y;
        end
        if (w <= 0 || h <= 0) begin
            ok = 1'b0;
        end
        return make_cmd(ok, x, y, w, h);
    endfunction

    function automatic t_cmd horiz(input t_coord x_in, input t_coord y, input t_coord len_in);
        t_coord x;
        t_coord len;
        logic   ok;
        x   = x_in;
        len = len_in;
        ok  = (y >= 0) && (y < DISP_H) && (len > 0);
        if (x < 0) begin
            len = len + x;
            x   = '0;
        end
        if (x + len > DISP_W) begin
            len = DISP_W - x;
        end
        if (len <= 0) begin
            ok = 1'b0;
        end
        return make_cmd(ok, x, y, len, t_coord'(1));
    endfunction

    function automatic t_cmd vert(input t_coord x, input t_coord y_in, input t_coord len_in);
        t_coord y;
        t_coord len;
        logic   ok;
        y   = y_in;
        len = len_in;
        ok  = (x >= 0) && (x < DISP_W) && (len > 0);
        if (y < 0) begin
            len = len + y;
            y   = '0;
        end
        if (y + len > DISP_H) begin
            len = DISP_H - y;
        end
        if (len <= 0) begin
            ok = 1'b0;
        end
        return make_cmd(ok, x, y, t_coord'(1), len);
    endfunction

endpackage

FILE: rtl/sprite_move_rect_command_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_move_rect_command_generator
// Tracks one rectangle sprite and turns move beats into clipped fill commands.
// ----------------------------------------------------------------------------
// A move's first command passes the input, move, command buffer and output registers.
// Throughput: one command per cycle while i_out_ready does not stall the
//   output; a move holds the command buffer until all of its commands (up
//   to 10) have been popped through the single output port.
// Place beats and moves on an absent sprite give no commands and never wait on the buffer.
// Reset: registers to defaults, sprite absent at (0,0), pipeline empty.
// ----------------------------------------------------------------------------
module sprite_move_rect_command_generator
    import smrcg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [8:0]        i_place_x,
    input  logic [8:0]        i_place_y,
    input  logic signed [9:0] i_delta_x,
    input  logic signed [9:0] i_delta_y,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_rect_x,
    output logic [8:0]        o_rect_y,
    output logic [7:0]        o_rect_w,
    output logic [8:0]        o_rect_h,
    output logic [15:0]       o_rect_color,
    output logic              o_last
);

    logic [7:0]  r_border_left;
    logic [8:0]  r_border_top;
    logic [7:0]  r_border_width;
    logic [8:0]  r_border_height;
    logic [7:0]  r_sprite_width;
    logic [8:0]  r_sprite_height;
    logic [15:0] r_fg_color;
    logic [15:0] r_bg_color;

    logic [8:0]  r_pos_x;
    logic [8:0]  r_pos_y;
    logic        r_present;

    logic              r_in_vld;
    logic              r_in_op;
    logic [8:0]        r_in_px;
    logic [8:0]        r_in_py;
    logic signed [9:0] r_in_dx;
    logic signed [9:0] r_in_dy;

    logic   r_mv_vld;
    t_coord r_mv_ox;
    t_coord r_mv_oy;
    t_coord r_mv_nx;
    t_coord r_mv_ny;

    t_cmd               r_cmd [NUM_CMD];
    logic [NUM_CMD-1:0] r_mask;

    logic        r_out_vld;
    t_cmd        r_out_cmd;
    logic [15:0] r_out_color;
    logic        r_out_last;

    t_coord w_bl;
    t_coord w_bt;
    t_coord w_bw;
    t_coord w_bh;
    t_coord w_sw;
    t_coord w_sh;
    t_coord w_hx;
    t_coord w_hy;
    t_coord w_nx;
    t_coord w_ny;

    t_coord w_dx;
    t_coord w_dy;
    t_coord w_adx;
    t_coord w_ady;
    t_coord w_cx;
    t_coord w_cy;
    t_coord w_rx2;
    t_coord w_ry2;
    t_coord w_bbx;
    t_coord w_bby;

    t_cmd               w_cand [NUM_CMD];
    logic [NUM_CMD-1:0] w_cand_vld;
    logic [NUM_CMD-1:0] w_low;
    logic [NUM_CMD-1:0] w_rest;
    t_cmd               w_pick;

    logic w_in_move;
    logic w_in_adv;
    logic w_mv_take;
    logic w_mv_adv;
    logic w_pop;
    logic w_cb_free;
    logic w_cb_load;

    assign o_cfg_ready = 1'b1;

    // handshake
    assign w_pop     = (r_mask != '0) && (!r_out_vld || i_out_ready);
    assign w_low     = r_mask & (~r_mask + NUM_CMD'(1));
    assign w_rest    = r_mask & ~w_low;
    assign w_cb_free = (r_mask == '0) || ((w_rest == '0) && w_pop);
    assign w_mv_adv  = r_mv_vld && w_cb_free;
    assign w_cb_load = w_mv_adv;
    assign w_mv_take = !r_mv_vld || w_mv_adv;
    assign w_in_move = r_in_vld && (r_in_op == OP_MOVE) && r_present;
    assign w_in_adv  = r_in_vld && (!w_in_move || w_mv_take);
    assign o_in_ready = !r_in_vld || w_in_adv;

    // clamp
    assign w_bl = t_coord'(r_border_left);
    assign w_bt = t_coord'(r_border_top);
    assign w_bw = t_coord'(r_border_width);
    assign w_bh = t_coord'(r_border_height);
    assign w_sw = t_coord'(r_sprite_width);
    assign w_sh = t_coord'(r_sprite_height);
    assign w_hx = w_bl + w_bw - w_sw;
    assign w_hy = w_bt + w_bh - w_sh;
    assign w_nx = clampv(t_coord'(r_pos_x) + t_coord'(r_in_dx), w_bl, w_hx);
    assign w_ny = clampv(t_coord'(r_pos_y) + t_coord'(r_in_dy), w_bt, w_hy);

    // command build
    assign w_dx  = r_mv_nx - r_mv_ox;
    assign w_dy  = r_mv_ny - r_mv_oy;
    assign w_adx = (w_dx < 0) ? -w_dx : w_dx;
    assign w_ady = (w_dy < 0) ? -w_dy : w_dy;
    assign w_cx  = clampv(r_mv_nx, w_bl, w_hx);
    assign w_cy  = clampv(r_mv_ny, w_bt, w_hy);
    assign w_rx2 = r_mv_nx + w_sw - t_coord'(1);
    assign w_ry2 = r_mv_ny + w_sh - t_coord'(1);
    assign w_bbx = w_bl + w_bw - t_coord'(1);
    assign w_bby = w_bt + w_bh - t_coord'(1);

    always_comb begin
        w_cand[0] = (w_dx != 0)
            ? fill_clipped((w_dx > 0) ? r_mv_ox : r_mv_ox + w_sw - w_adx,
                           (w_dy >= 0) ? r_mv_oy : r_mv_oy + w_dy,
                           w_adx, w_sh + w_ady)
            : '0;
        w_cand[1] = (w_dy != 0)
            ? fill_clipped((w_dx >= 0) ? r_mv_ox + w_adx : r_mv_ox,
                           (w_dy > 0) ? r_mv_oy : r_mv_oy + w_sh - w_ady,
                           w_sw - w_adx, w_ady)
            : '0;
        w_cand[2] = horiz(w_cx, w_cy, w_sw);
        w_cand[3] = horiz(w_cx, w_cy + w_sh - t_coord'(1), w_sw);
        w_cand[4] = vert(w_cx, w_cy, w_sh);
        w_cand[5] = vert(w_cx + w_sw - t_coord'(1), w_cy, w_sh);
        w_cand[6] = (r_mv_ny <= w_bt && w_ry2 >= w_bt) ? horiz(w_bl, w_bt, w_bw) : '0;
        w_cand[7] = (r_mv_ny <= w_bby && w_ry2 >= w_bby) ? horiz(w_bl, w_bby, w_bw) : '0;
        w_cand[8] = (r_mv_nx <= w_bl && w_rx2 >= w_bl) ? vert(w_bl, w_bt, w_bh) : '0;
        w_cand[9] = (r_mv_nx <= w_bbx && w_rx2 >= w_bbx) ? vert(w_bbx, w_bt, w_bh) : '0;
        for (int i = 0; i < NUM_CMD; i++) begin
            w_cand_vld[i] = w_cand[i].vld;
        end
    end

    // select lowest pending command
    always_comb begin
        w_pick = '0;
        for (int i = 0; i < NUM_CMD; i++) begin
            if (w_low[i]) begin
                w_pick = w_pick | r_cmd[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border_left   <= 8'd0;
            r_border_top    <= 9'd0;
            r_border_width  <= 8'd240;
            r_border_height <= 9'd320;
            r_sprite_width  <= 8'd8;
            r_sprite_height <= 9'd8;
            r_fg_color      <= 16'hFFFF;
            r_bg_color      <= 16'h0000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BORDER_LEFT:   r_border_left   <= i_cfg_data[7:0];
                CFG_BORDER_TOP:    r_border_top    <= i_cfg_data[8:0];
                CFG_BORDER_WIDTH:  r_border_width  <= i_cfg_data[7:0];
                CFG_BORDER_HEIGHT: r_border_height <= i_cfg_data[8:0];
                CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[7:0];
                CFG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data[8:0];
                CFG_FG_COLOR:      r_fg_color      <= i_cfg_data;
                CFG_BG_COLOR:      r_bg_color      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_present <= 1'b0;
            r_in_vld  <= 1'b0;
            r_mv_vld  <= 1'b0;
            r_mask    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_in_adv) begin
                if (r_in_op == OP_PLACE) begin
                    r_pos_x   <= r_in_px;
                    r_pos_y   <= r_in_py;
                    r_present <= 1'b1;
                end else if (r_present) begin
                    r_pos_x <= sat9(w_nx);
                    r_pos_y <= sat9(w_ny);
                end
            end
            if (w_mv_take) begin
                r_mv_vld <= w_in_adv && w_in_move;
            end
            if (w_cb_load) begin
                r_mask <= w_cand_vld;
            end else if (w_pop) begin
                r_mask <= w_rest;
            end
            if (w_pop) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_op <= i_operation;
            r_in_px <= i_place_x;
            r_in_py <= i_place_y;
            r_in_dx <= i_delta_x;
            r_in_dy <= i_delta_y;
        end
        if (w_mv_take) begin
            r_mv_ox <= t_coord'(r_pos_x);
            r_mv_oy <= t_coord'(r_pos_y);
            r_mv_nx <= w_nx;
            r_mv_ny <= w_ny;
        end
        if (w_cb_load) begin
            for (int i = 0; i < NUM_CMD; i++) begin
                r_cmd[i] <= w_cand[i];
            end
        end
        if (w_pop) begin
            r_out_cmd   <= w_pick;
            r_out_color <= (w_low[NUM_ERASE-1:0] != '0) ? r_bg_color : r_fg_color;
            r_out_last  <= (w_rest == '0);
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_rect_x     = r_out_cmd.x;
    assign o_rect_y     = r_out_cmd.y;
    assign o_rect_w     = r_out_cmd.w;
    assign o_rect_h     = r_out_cmd.h;
    assign o_rect_color = r_out_color;
    assign o_last       = r_out_last;

    a_place_sets_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_adv && r_in_op == OP_PLACE) |=> r_present)
        else $error("place beat did not mark sprite present");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_adv |=> ($stable(r_pos_x) && $stable(r_pos_y)))
        else $error("position changed without an input beat");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |-> (r_mask != '0))
        else $error("non-final command shown with empty command buffer");

    a_mask_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cb_load |=> ((r_mask & ~$past(r_mask)) == '0))
        else $error("command buffer gained entries without a load");

endmodule
